// ===== sv/qrfpc_pkg.sv =====
`default_nettype none

package qrfpc_pkg;

  localparam int unsigned MAX_ALIGN = 7;
  localparam int unsigned NUM_VERSIONS = 40;

  localparam logic [5:0] VERSION_MIN = 6'd1;
  localparam logic [5:0] VERSION_MAX = 6'd40;
  localparam logic [5:0] VERSION_INFO_MIN = 6'd7;

  // Fixed coordinates of the timing lines, the format strips and the dark module column.
  localparam logic [7:0] TIMING_LINE = 8'd6;
  localparam logic [7:0] FORMAT_LINE = 8'd8;
  localparam logic [7:0] FINDER_SIZE = 8'd7;
  localparam logic [7:0] FINDER_BOX = 8'd8;
  localparam logic [7:0] VERSION_DEPTH = 8'd6;

  typedef enum logic [1:0] {
    CLS_DATA     = 2'd0,
    CLS_LIGHT    = 2'd1,
    CLS_DARK     = 2'd2,
    CLS_RESERVED = 2'd3
  } module_class_t;

  // Per version: number of alignment center coordinates, then the coordinates.
  localparam logic [7:0] ALIGN_TAB [NUM_VERSIONS][8] = '{
    '{8'd0, 8'd0, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd2, 8'd6, 8'd18,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd2, 8'd6, 8'd22,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd2, 8'd6, 8'd26,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd2, 8'd6, 8'd30,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd2, 8'd6, 8'd34,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd3, 8'd6, 8'd22,  8'd38,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd3, 8'd6, 8'd24,  8'd42,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd3, 8'd6, 8'd26,  8'd46,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd3, 8'd6, 8'd28,  8'd50,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd3, 8'd6, 8'd30,  8'd54,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd3, 8'd6, 8'd32,  8'd58,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd3, 8'd6, 8'd34,  8'd62,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd4, 8'd6, 8'd26,  8'd46,  8'd66,  8'd0,   8'd0,   8'd0},
    '{8'd4, 8'd6, 8'd26,  8'd48,  8'd70,  8'd0,   8'd0,   8'd0},
    '{8'd4, 8'd6, 8'd26,  8'd50,  8'd74,  8'd0,   8'd0,   8'd0},
    '{8'd4, 8'd6, 8'd30,  8'd54,  8'd78,  8'd0,   8'd0,   8'd0},
    '{8'd4, 8'd6, 8'd30,  8'd56,  8'd82,  8'd0,   8'd0,   8'd0},
    '{8'd4, 8'd6, 8'd30,  8'd58,  8'd86,  8'd0,   8'd0,   8'd0},
    '{8'd4, 8'd6, 8'd34,  8'd62,  8'd90,  8'd0,   8'd0,   8'd0},
    '{8'd5, 8'd6, 8'd28,  8'd50,  8'd72,  8'd94,  8'd0,   8'd0},
    '{8'd5, 8'd6, 8'd26,  8'd50,  8'd74,  8'd98,  8'd0,   8'd0},
    '{8'd5, 8'd6, 8'd30,  8'd54,  8'd78,  8'd102, 8'd0,   8'd0},
    '{8'd5, 8'd6, 8'd28,  8'd54,  8'd80,  8'd106, 8'd0,   8'd0},
    '{8'd5, 8'd6, 8'd32,  8'd58,  8'd84,  8'd110, 8'd0,   8'd0},
    '{8'd5, 8'd6, 8'd30,  8'd58,  8'd86,  8'd114, 8'd0,   8'd0},
    '{8'd5, 8'd6, 8'd34,  8'd62,  8'd90,  8'd118, 8'd0,   8'd0},
    '{8'd6, 8'd6, 8'd26,  8'd50,  8'd74,  8'd98,  8'd122, 8'd0},
    '{8'd6, 8'd6, 8'd30,  8'd54,  8'd78,  8'd102, 8'd126, 8'd0},
    '{8'd6, 8'd6, 8'd26,  8'd52,  8'd78,  8'd104, 8'd130, 8'd0},
    '{8'd6, 8'd6, 8'd30,  8'd56,  8'd82,  8'd108, 8'd134, 8'd0},
    '{8'd6, 8'd6, 8'd34,  8'd60,  8'd86,  8'd112, 8'd138, 8'd0},
    '{8'd6, 8'd6, 8'd30,  8'd58,  8'd86,  8'd114, 8'd142, 8'd0},
    '{8'd6, 8'd6, 8'd34,  8'd62,  8'd90,  8'd118, 8'd146, 8'd0},
    '{8'd7, 8'd6, 8'd30,  8'd54,  8'd78,  8'd102, 8'd126, 8'd150},
    '{8'd7, 8'd6, 8'd24,  8'd50,  8'd76,  8'd102, 8'd128, 8'd154},
    '{8'd7, 8'd6, 8'd28,  8'd54,  8'd80,  8'd106, 8'd132, 8'd158},
    '{8'd7, 8'd6, 8'd32,  8'd58,  8'd84,  8'd110, 8'd136, 8'd162},
    '{8'd7, 8'd6, 8'd26,  8'd54,  8'd82,  8'd110, 8'd138, 8'd166},
    '{8'd7, 8'd6, 8'd30,  8'd58,  8'd86,  8'd114, 8'd142, 8'd170}
  };

  // Symbol geometry derived once per version write.
  typedef struct packed {
    logic [7:0]                 side;
    logic [7:0]                 side_m7;
    logic [7:0]                 side_m8;
    logic [7:0]                 side_m11;
    logic                       ver_info;
    logic [2:0]                 n_align;
    logic [2:0]                 last_align;
    logic [MAX_ALIGN-1:0][7:0]  centers;
  } geom_t;

  typedef struct packed {
    logic hit;
    logic light;
  } align_hit_t;

  function automatic logic [5:0] clamp_version(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (v < VERSION_MIN) r = VERSION_MIN;
    if (v > VERSION_MAX) r = VERSION_MAX;
    return r;
  endfunction

  function automatic geom_t geom_of_version(input logic [5:0] v);
    geom_t      g;
    logic [5:0] idx;
    logic [7:0] s;
    idx = v - VERSION_MIN;
    s = {v, 2'b00} + 8'd17;
    g.side = s;
    g.side_m7 = s - 8'd7;
    g.side_m8 = s - 8'd8;
    g.side_m11 = s - 8'd11;
    g.ver_info = (v >= VERSION_INFO_MIN);
    g.n_align = ALIGN_TAB[idx][0][2:0];
    g.last_align = (g.n_align == 3'd0) ? 3'd0 : g.n_align - 3'd1;
    for (int k = 0; k < MAX_ALIGN; k++) begin
      g.centers[k] = ALIGN_TAB[idx][k+1];
    end
    return g;
  endfunction

  // Finder cell at offset (dx, dy) 0..6 from its top-left corner.
  function automatic module_class_t finder_cell(input logic [2:0] dx, input logic [2:0] dy);
    logic ring;
    ring = ((dx == 3'd1 || dx == 3'd5) && dy >= 3'd1 && dy <= 3'd5) ||
           ((dy == 3'd1 || dy == 3'd5) && dx >= 3'd1 && dx <= 3'd5);
    return ring ? CLS_LIGHT : CLS_DARK;
  endfunction

endpackage

`default_nettype wire

// ===== sv/qrfpc_cfg.sv =====
`default_nettype none

module qrfpc_cfg import qrfpc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [5:0] cfg_wr_data,
  output geom_t           geom
);

  // The version is decoded into geometry at write time, so the per-module
  // path only sees registered constants.
  always_ff @(posedge clk) begin
    if (rst) begin
      geom <= geom_of_version(VERSION_MIN);
    end else if (cfg_wr_en) begin
      geom <= geom_of_version(clamp_version(cfg_wr_data));
    end
  end

endmodule

`default_nettype wire

// ===== sv/qrfpc_align.sv =====
`default_nettype none

module qrfpc_align import qrfpc_pkg::*; (
  input  wire logic [7:0] x,
  input  wire logic [7:0] y,
  input  wire geom_t      geom,
  output align_hit_t      hit
);

  logic [MAX_ALIGN-1:0] near_x, near_y;
  logic [1:0]           mag_x [MAX_ALIGN];
  logic [1:0]           mag_y [MAX_ALIGN];
  logic signed [8:0]    dx [MAX_ALIGN];
  logic signed [8:0]    dy [MAX_ALIGN];
  logic [2:0]           ix, iy;
  logic [1:0]           ax, ay;
  logic                 corner;

  always_comb begin
    for (int i = 0; i < MAX_ALIGN; i++) begin
      dx[i] = $signed({1'b0, x}) - $signed({1'b0, geom.centers[i]});
      dy[i] = $signed({1'b0, y}) - $signed({1'b0, geom.centers[i]});
      near_x[i] = (3'(i) < geom.n_align) && dx[i] >= -9'sd2 && dx[i] <= 9'sd2;
      near_y[i] = (3'(i) < geom.n_align) && dy[i] >= -9'sd2 && dy[i] <= 9'sd2;
      mag_x[i] = dx[i][8] ? 2'(-dx[i]) : dx[i][1:0];
      mag_y[i] = dy[i][8] ? 2'(-dy[i]) : dy[i][1:0];
    end
  end

  // Centers are at least 12 apart, so at most one lane matches per axis.
  always_comb begin
    ix = '0;
    iy = '0;
    ax = '0;
    ay = '0;
    for (int i = 0; i < MAX_ALIGN; i++) begin
      ix |= near_x[i] ? 3'(i) : 3'd0;
      iy |= near_y[i] ? 3'(i) : 3'd0;
      ax |= near_x[i] ? mag_x[i] : 2'd0;
      ay |= near_y[i] ? mag_y[i] : 2'd0;
    end
  end

  // The three center pairs that fall on finder corners carry no pattern.
  assign corner = (ix == 3'd0 && iy == 3'd0) ||
                  (ix == 3'd0 && iy == geom.last_align) ||
                  (ix == geom.last_align && iy == 3'd0);

  assign hit.hit = (|near_x) && (|near_y) && !corner;
  assign hit.light = (ax <= 2'd1) && (ay <= 2'd1) && !(ax == 2'd0 && ay == 2'd0);

endmodule

`default_nettype wire

// ===== sv/qrfpc_class.sv =====
`default_nettype none

module qrfpc_class import qrfpc_pkg::*; (
  input  wire logic [7:0] x,
  input  wire logic [7:0] y,
  input  wire geom_t      geom,
  output module_class_t   cls,
  output logic            outside
);

  align_hit_t    ahit;
  module_class_t c;
  logic [7:0]    off_x, off_y;

  qrfpc_align u_align (
    .x    (x),
    .y    (y),
    .geom (geom),
    .hit  (ahit)
  );

  assign outside = (x >= geom.side) || (y >= geom.side);
  assign off_x = x - geom.side_m7;
  assign off_y = y - geom.side_m7;

  // Areas are applied in drawing order; a later area overrides an earlier one.
  always_comb begin
    c = CLS_DATA;

    if (x < FINDER_BOX && y < FINDER_BOX) begin
      c = (x < FINDER_SIZE && y < FINDER_SIZE) ? finder_cell(x[2:0], y[2:0]) : CLS_LIGHT;
    end
    if (x >= geom.side_m8 && y < FINDER_BOX) begin
      c = (x >= geom.side_m7 && y < FINDER_SIZE) ? finder_cell(off_x[2:0], y[2:0])
                                                  : CLS_LIGHT;
    end
    if (x < FINDER_BOX && y >= geom.side_m8) begin
      c = (x < FINDER_SIZE && y >= geom.side_m7) ? finder_cell(x[2:0], off_y[2:0])
                                                  : CLS_LIGHT;
    end

    if (y == TIMING_LINE && x >= FINDER_BOX && x < geom.side_m8) begin
      c = x[0] ? CLS_LIGHT : CLS_DARK;
    end
    if (x == TIMING_LINE && y >= FINDER_BOX && y < geom.side_m8) begin
      c = y[0] ? CLS_LIGHT : CLS_DARK;
    end

    if (ahit.hit) begin
      c = ahit.light ? CLS_LIGHT : CLS_DARK;
    end

    if (x == FORMAT_LINE && y == geom.side_m8) begin
      c = CLS_DARK;
    end

    if (y == FORMAT_LINE && x < FINDER_BOX && x != TIMING_LINE) c = CLS_RESERVED;
    if (x == FORMAT_LINE && y <= FORMAT_LINE && y != TIMING_LINE) c = CLS_RESERVED;
    if (x == FORMAT_LINE && y >= geom.side_m7) c = CLS_RESERVED;
    if (y == FORMAT_LINE && x >= geom.side_m8) c = CLS_RESERVED;

    if (geom.ver_info) begin
      if (x < VERSION_DEPTH && y >= geom.side_m11 && y < geom.side_m8) c = CLS_RESERVED;
      if (y < VERSION_DEPTH && x >= geom.side_m11 && x < geom.side_m8) c = CLS_RESERVED;
    end

    cls = outside ? CLS_DATA : c;
  end

endmodule

`default_nettype wire

// ===== sv/qr_function_pattern_classifier_core.sv =====
// QR function pattern classifier.
//
// A coordinate (col, row) is a transaction, taken at a rising edge where start
// is high and busy is low. busy never rises, so a new coordinate can be given
// in every cycle, for instance one module per clock in raster order.
// Once taken, a transaction passes the input register and then the result
// register; done is then high for exactly one cycle with module_class,
// out_of_matrix and matrix_side; transactions come out in order. Throughput is
// one coordinate per cycle: input and result register form a two-stage pipeline.
// The symbol version is written through cfg_wr_en / cfg_wr_data; the user must do
// so only while no transaction is in flight (not enforced by the block). It is
// decoded into side length and alignment centers in the same edge. Out-of-range
// versions act as the nearest of 1 and 40. Reset sets the version to 1 and drops
// any transaction in flight; no done strobe follows until a new start. The
// receiver cannot stall, so results are never held back.
`default_nettype none

module qr_function_pattern_classifier_core import qrfpc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] col,
  input  wire logic [7:0] row,
  input  wire logic       cfg_wr_en,
  input  wire logic [5:0] cfg_wr_data,
  output logic            done,
  output logic [1:0]      module_class,
  output logic            out_of_matrix,
  output logic [7:0]      matrix_side
);

  geom_t         geom;
  logic          in_valid;
  logic [7:0]    col_q, row_q;
  module_class_t cls_next;
  logic          outside_next;

  assign busy = 1'b0;

  qrfpc_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .geom        (geom)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    col_q <= col;
    row_q <= row;
  end

  qrfpc_class u_class (
    .x       (col_q),
    .y       (row_q),
    .geom    (geom),
    .cls     (cls_next),
    .outside (outside_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    module_class <= cls_next;
    out_of_matrix <= outside_next;
    matrix_side <= geom.side;
  end

endmodule

`default_nettype wire

// ===== sv/qrfpc_checker.sv =====
`default_nettype none

module qrfpc_checker import qrfpc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [7:0] col,
  input wire logic [7:0] row,
  input wire logic       done,
  input wire logic [1:0] module_class,
  input wire logic       out_of_matrix,
  input wire logic [7:0] matrix_side
);

  // Every taken transaction yields its result once it has passed the input and result registers.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done)
    else $error("result strobe missing after taken transaction");

  // The reported side is always 4V+17 for V in 1..40.
  assert property (@(posedge clk) disable iff (rst)
    done |-> matrix_side[1:0] == 2'b01 && matrix_side >= 8'd21 && matrix_side <= 8'd177)
    else $error("matrix side not a legal 4V+17");

  // The outside flag agrees with the coordinate and the side reported with it.
  assert property (@(posedge clk) disable iff (rst)
    done |-> out_of_matrix == ($past(col, 2) >= matrix_side || $past(row, 2) >= matrix_side))
    else $error("out_of_matrix disagrees with coordinate");

  assert property (@(posedge clk) disable iff (rst)
    done && out_of_matrix |-> module_class == CLS_DATA)
    else $error("class not data for a coordinate outside the matrix");

  // The top-left corner is always a dark finder module.
  assert property (@(posedge clk) disable iff (rst)
    done && $past(col, 2) == 8'd0 && $past(row, 2) == 8'd0 |-> module_class == CLS_DARK)
    else $error("top-left finder corner not dark");

endmodule

bind qr_function_pattern_classifier_core qrfpc_checker u_checker (.*);

`default_nettype wire
